// ===== rtl/ocs_pkg.sv =====
// ----------------------------------------------------------------------------
// ocs_pkg
// shared widths, register codes, reset values and types of the chip slicer
// ----------------------------------------------------------------------------
`default_nettype none

package ocs_pkg;

  localparam int POS_W    = 40;
  localparam int ACC_W    = 56;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 17;
  localparam int NUM_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int SKIP_W   = 24;
  localparam int PER_W    = 24;
  localparam int HALF_W   = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int MAX_CHIPS_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [SKIP_W-1:0] SKIP_RST   = 24'd0;
  localparam logic [PER_W-1:0]  PERIOD_RST = 24'd4266667;
  localparam logic [HALF_W-1:0] HALF_RST   = 8'd32;
  localparam logic [CNT_W-1:0]  TOTAL_RST  = 17'd38400;

  typedef enum logic [1:0] {
    REG_SKIP,
    REG_PERIOD,
    REG_HALF,
    REG_TOTAL
  } reg_idx_t;

  typedef struct packed {
    logic [SKIP_W-1:0] skip_samples;
    logic [PER_W-1:0]  chip_period_q16;
    logic [HALF_W-1:0] half_chip_samples;
    logic [CNT_W-1:0]  chip_total;
  } cfg_t;

  typedef struct packed {
    logic             chip_i;
    logic             chip_q;
    logic [NUM_W-1:0] chip_number;
    logic             final_chip;
  } res_t;

endpackage : ocs_pkg

`default_nettype wire

// ===== rtl/oqpsk_chip_slicer.sv =====
// ----------------------------------------------------------------------------
// oqpsk_chip_slicer
// integrate-and-dump chip slicer for offset-qpsk samples
//
// the input channel carries one signed i/q sample pair per transfer; the
// output channel carries one chip (two rail decisions, chip index and a last
// flag) at the end of each chip window. the apb port sets the leading skip,
// the q16 chip period, the q rail offset and the chip count. the user must
// write it only while the block is idle; the block does not enforce this.
// throughput is one sample per cycle while the output is not stalled, since
// the window accumulator and the two sums update as each sample is taken. a
// sample passes an input register and then the update logic; a chip closed
// by a sample enters the output register as that sample leaves the input
// register. out_* hold while out_stall is high; the input register keeps
// taking one more sample, and in_stall rises once that register and the
// output register are both full and the output is stalled.
// reset clears counters, sums and valid flags and loads register defaults;
// past the chip count it drops every sample until the count is raised or reset.
// ----------------------------------------------------------------------------
`default_nettype none

module oqpsk_chip_slicer
  import ocs_pkg::*;
#(
  parameter int MAX_CHIPS   = MAX_CHIPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] in_q_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_chip_i,
  output logic                               out_chip_q,
  output logic             [NUM_W-1:0]       out_chip_number,
  output logic                               out_final_chip,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [ADDR_W-1:0]      paddr,
  input  wire logic        [DATA_W-1:0]      pwdata,
  output logic             [DATA_W-1:0]      prdata,
  output logic                               pready
);

  cfg_t                          cfg;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_i_r;
  logic signed [SAMPLE_BITS-1:0] s1_q_r;
  logic                          go;
  logic                          in_xfer;
  logic                          res_vld;
  res_t                          res;
  logic                          out_valid_r;
  res_t                          out_r;

  ocs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ocs_core #(
    .MAX_CHIPS   (MAX_CHIPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (go),
    .i_sample (s1_i_r),
    .q_sample (s1_q_r),
    .cfg      (cfg),
    .res_vld  (res_vld),
    .res      (res)
  );

  assign go       = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !go;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_i_r <= in_i_sample;
      s1_q_r <= in_q_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chip_i      = out_r.chip_i;
  assign out_chip_q      = out_r.chip_q;
  assign out_chip_number = out_r.chip_number;
  assign out_final_chip  = out_r.final_chip;

endmodule : oqpsk_chip_slicer

`default_nettype wire

// ===== rtl/ocs_cfg.sv =====
// ----------------------------------------------------------------------------
// ocs_cfg
// apb register file holding the slicer configuration
// ----------------------------------------------------------------------------
`default_nettype none

module ocs_cfg
  import ocs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_SKIP:   cfg_nxt.skip_samples      = pwdata[SKIP_W-1:0];
        REG_PERIOD: cfg_nxt.chip_period_q16   = pwdata[PER_W-1:0];
        REG_HALF:   cfg_nxt.half_chip_samples = pwdata[HALF_W-1:0];
        REG_TOTAL:  cfg_nxt.chip_total        = pwdata[CNT_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SKIP:   prdata = DATA_W'(cfg_r.skip_samples);
      REG_PERIOD: prdata = DATA_W'(cfg_r.chip_period_q16);
      REG_HALF:   prdata = DATA_W'(cfg_r.half_chip_samples);
      REG_TOTAL:  prdata = DATA_W'(cfg_r.chip_total);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_samples      <= SKIP_RST;
      cfg_r.chip_period_q16   <= PERIOD_RST;
      cfg_r.half_chip_samples <= HALF_RST;
      cfg_r.chip_total        <= TOTAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : ocs_cfg

`default_nettype wire

// ===== rtl/ocs_core.sv =====
// ----------------------------------------------------------------------------
// ocs_core
// window tracking, integrate-and-dump sums and chip decisions, one sample
// per cycle while fire is high
// ----------------------------------------------------------------------------
`default_nettype none

module ocs_core
  import ocs_pkg::*;
#(
  parameter int MAX_CHIPS   = MAX_CHIPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  input  wire cfg_t                          cfg,
  output logic                               res_vld,
  output res_t                               res
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHIPS);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  logic        [POS_W-1:0] pos_r;
  logic        [ACC_W-1:0] acc_r;
  logic signed [SUM_W-1:0] isum_r;
  logic signed [SUM_W-1:0] qsum_r;
  logic        [CNT_W-1:0] cnt_r;

  logic        [CNT_W-1:0] total;
  logic                    done;
  logic                    pre;
  logic        [POS_W-1:0] rel;
  logic        [ACC_W-1:0] acc_nxt;
  logic        [POS_W-1:0] win_start;
  logic        [POS_W-1:0] win_end;
  logic                    in_win;
  logic                    q_ok;
  logic signed [SUM_W-1:0] iv;
  logic signed [SUM_W-1:0] qv;
  logic signed [SUM_W-1:0] isum_nxt;
  logic signed [SUM_W-1:0] qsum_nxt;

  always_comb begin
    total     = (cfg.chip_total > MAX_CNT) ? MAX_CNT : cfg.chip_total;
    done      = cnt_r >= total;
    pre       = pos_r < POS_W'(cfg.skip_samples);
    rel       = pos_r - POS_W'(cfg.skip_samples);
    acc_nxt   = acc_r + ACC_W'(cfg.chip_period_q16);
    win_start = acc_r[ACC_W-1:FRAC_W];
    win_end   = acc_nxt[ACC_W-1:FRAC_W];
    in_win    = (rel >= win_start) && (rel < win_end);
    q_ok      = {1'b0, rel} >= ({1'b0, win_start} + (POS_W+1)'(cfg.half_chip_samples));
    iv        = {{(SUM_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
    qv        = {{(SUM_W-SAMPLE_BITS){q_sample[SAMPLE_BITS-1]}}, q_sample};
    isum_nxt  = in_win ? sat_add(isum_r, iv) : isum_r;
    qsum_nxt  = (in_win && q_ok) ? sat_add(qsum_r, qv) : qsum_r;
    res_vld   = fire && !done && !pre &&
                (({1'b0, rel} + (POS_W+1)'(1)) >= {1'b0, win_end});
    res.chip_i      = isum_nxt > 0;
    res.chip_q      = qsum_nxt > 0;
    res.chip_number = cnt_r[NUM_W-1:0];
    res.final_chip  = cnt_r == (total - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      isum_r <= '0;
      qsum_r <= '0;
      cnt_r  <= '0;
    end else if (fire && !done) begin
      if (pos_r != POS_MAX) begin
        pos_r <= pos_r + POS_W'(1);
      end
      if (!pre) begin
        if (res_vld) begin
          isum_r <= '0;
          qsum_r <= '0;
          cnt_r  <= cnt_r + CNT_W'(1);
          acc_r  <= acc_nxt;
        end else begin
          isum_r <= isum_nxt;
          qsum_r <= qsum_nxt;
        end
      end
    end
  end

endmodule : ocs_core

`default_nettype wire

// ===== tb/oqpsk_chip_slicer_test.sv =====
// ----------------------------------------------------------------------------
// oqpsk_chip_slicer_test
// self-checking bench for the offset-qpsk chip slicer
//
// a clocked driver sends i/q samples from a backlog that the main sequence
// fills, and a clocked monitor checks every chip transfer against the chip
// that the bench's own slicer predicted when the sample was taken. a short
// directed run covers sample extremes, the leading skip, periods below one
// sample, samples that land past the window end, a zero chip count and the
// stop after the last chip. random phases then rewrite the registers between
// bursts of biased and noisy samples, with random input gaps and output
// stalls except in the last stretch.
// ----------------------------------------------------------------------------
module oqpsk_chip_slicer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ocs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 16;
  localparam int TARGET      = 1950;
  localparam int CALM_TAIL   = 300;

  localparam longint SUM_TOP = 64'sd549755813887;
  localparam longint SUM_BOT = -SUM_TOP - 1;

  typedef struct {
    logic signed [SAMPLE_BITS_DEF-1:0] i_s;
    logic signed [SAMPLE_BITS_DEF-1:0] q_s;
  } iq_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic signed [SAMPLE_BITS_DEF-1:0] in_i_sample = '0;
  logic signed [SAMPLE_BITS_DEF-1:0] in_q_sample = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  logic                              out_chip_i;
  logic                              out_chip_q;
  logic        [NUM_W-1:0]           out_chip_number;
  logic                              out_final_chip;
  logic                              psel        = 1'b0;
  logic                              penable     = 1'b0;
  logic                              pwrite      = 1'b0;
  logic        [ADDR_W-1:0]          paddr       = '0;
  logic        [DATA_W-1:0]          pwdata      = '0;
  logic        [DATA_W-1:0]          prdata;
  logic                              pready;

  iq_t  iq_backlog[$];
  res_t chips_owed[$];
  int   samples_queued = 0;
  int   samples_taken  = 0;
  int   mismatches     = 0;
  int   quiet_cycles   = 0;
  int   gap_left       = 0;
  int   stall_left     = 0;
  bit   gaps_on        = 1'b0;
  bit   stalls_on      = 1'b0;

  // slicer state as the bench sees it
  logic        [SKIP_W-1:0] skip_set   = SKIP_RST;
  logic        [PER_W-1:0]  period_set = PERIOD_RST;
  logic        [HALF_W-1:0] half_set   = HALF_RST;
  logic        [CNT_W-1:0]  total_set  = TOTAL_RST;
  logic        [POS_W-1:0]  sample_pos = '0;
  logic        [ACC_W-1:0]  boundary   = '0;
  logic signed [SUM_W-1:0]  i_sum      = '0;
  logic signed [SUM_W-1:0]  q_sum      = '0;
  logic        [CNT_W-1:0]  chips_done = '0;

  oqpsk_chip_slicer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_i_sample     (in_i_sample),
    .in_q_sample     (in_q_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chip_i      (out_chip_i),
    .out_chip_q      (out_chip_q),
    .out_chip_number (out_chip_number),
    .out_final_chip  (out_final_chip),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  function automatic logic signed [SUM_W-1:0] clip_sum(input longint v);
    if (v > SUM_TOP) return SUM_W'(SUM_TOP);
    if (v < SUM_BOT) return SUM_W'(SUM_BOT);
    return SUM_W'(v);
  endfunction

  function automatic bit slice_sample(input logic signed [SAMPLE_BITS_DEF-1:0] i_s,
                                      input logic signed [SAMPLE_BITS_DEF-1:0] q_s,
                                      output res_t chip);
    longint unsigned limit;
    longint unsigned pos;
    longint unsigned rel;
    longint unsigned w_start;
    longint unsigned w_end;
    chip  = '0;
    limit = (total_set > MAX_CHIPS_DEF) ? MAX_CHIPS_DEF : total_set;
    if (chips_done >= limit) return 1'b0;
    pos = sample_pos;
    if (sample_pos != '1) sample_pos = sample_pos + 1'b1;
    if (pos < skip_set) return 1'b0;
    rel     = pos - skip_set;
    w_start = boundary;
    w_end   = w_start + period_set;
    w_start = w_start >> FRAC_W;
    w_end   = w_end >> FRAC_W;
    if (rel >= w_start && rel < w_end) begin
      i_sum = clip_sum(longint'(i_sum) + longint'(i_s));
      if (rel >= w_start + half_set) q_sum = clip_sum(longint'(q_sum) + longint'(q_s));
    end
    if (rel + 1 < w_end) return 1'b0;
    chip.chip_i      = (i_sum > 0);
    chip.chip_q      = (q_sum > 0);
    chip.chip_number = chips_done[NUM_W-1:0];
    chip.final_chip  = (chips_done == limit - 1);
    chips_done       = chips_done + 1'b1;
    boundary         = boundary + period_set;
    i_sum            = '0;
    q_sum            = '0;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(posedge clk) begin
    res_t chip;
    iq_t  next_iq;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (slice_sample(in_i_sample, in_q_sample, chip)) chips_owed.push_back(chip);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (iq_backlog.size() != 0) begin
          next_iq = iq_backlog.pop_front();
          in_valid    <= 1'b1;
          in_i_sample <= next_iq.i_s;
          in_q_sample <= next_iq.q_s;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_chip_i, out_chip_q, out_chip_number, out_final_chip};
        if (chips_owed.size() == 0) begin
          report($sformatf("unexpected chip %0d i=%0b q=%0b last=%0b",
                           got.chip_number, got.chip_i, got.chip_q, got.final_chip));
        end else begin
          want = chips_owed.pop_front();
          if (got.chip_i !== want.chip_i || got.chip_q !== want.chip_q ||
              got.chip_number !== want.chip_number || got.final_chip !== want.final_chip)
            report($sformatf("expected chip %0d i=%0b q=%0b last=%0b, got chip %0d i=%0b q=%0b last=%0b",
                             want.chip_number, want.chip_i, want.chip_q, want.final_chip,
                             got.chip_number, got.chip_i, got.chip_q, got.final_chip));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] held;
    case (idx)
      REG_SKIP: begin
        skip_set = value[SKIP_W-1:0];
        held     = DATA_W'(skip_set);
      end
      REG_PERIOD: begin
        period_set = value[PER_W-1:0];
        held       = DATA_W'(period_set);
      end
      REG_HALF: begin
        half_set = value[HALF_W-1:0];
        held     = DATA_W'(half_set);
      end
      default: begin
        total_set = value[CNT_W-1:0];
        held      = DATA_W'(total_set);
      end
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== held)
      report($sformatf("register %s read %0h, wrote %0h", idx.name(), prdata, held));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_sample(input logic signed [SAMPLE_BITS_DEF-1:0] i_s,
                            input logic signed [SAMPLE_BITS_DEF-1:0] q_s);
    iq_t item;
    item.i_s = i_s;
    item.q_s = q_s;
    iq_backlog.push_back(item);
    samples_queued++;
  endtask

  // every sample taken and every chip back, then let the pipeline empty
  task automatic wait_idle();
    while (samples_taken != samples_queued) @(posedge clk);
    while (chips_owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample(input int lean);
    case ($urandom_range(0, 5))
      0:       return SAMPLE_BITS_DEF'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return SAMPLE_BITS_DEF'(lean + int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    logic [PER_W-1:0] period;
    int               lean;
    int               count;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one sample per chip, three leading samples dropped, count above the cap
    write_reg(REG_SKIP, 3);
    write_reg(REG_PERIOD, 65536);
    write_reg(REG_HALF, 0);
    write_reg(REG_TOTAL, 32'h1FFFF);
    add_sample(16'sh1234, -16'sd5);
    add_sample(16'sh7FFF, 16'sh7FFF);
    add_sample(16'sh8000, 16'sh8000);
    add_sample(16'sh7FFF, 16'sh8000);
    add_sample(16'sh8000, 16'sh7FFF);
    add_sample(16'sh0000, 16'sh0000);
    add_sample(16'sh0001, -16'sd1);
    add_sample(-16'sd1, 16'sh0001);
    wait_idle();

    // windows shorter than a sample, q offset past every window
    write_reg(REG_PERIOD, 0);
    write_reg(REG_HALF, 255);
    add_sample(16'sh4000, 16'sh4000);
    add_sample(-16'sd300, 16'sh0100);
    wait_idle();
    write_reg(REG_PERIOD, 30000);
    add_sample(16'sh7000, 16'sh7000);
    add_sample(16'sh7000, -16'sd20);
    add_sample(-16'sd9, 16'sh0004);
    wait_idle();

    // huge skip drops samples, then removing it puts samples past the window
    write_reg(REG_PERIOD, 98304);
    write_reg(REG_HALF, 1);
    write_reg(REG_SKIP, 32'hFFFFFF);
    add_sample(16'sh2222, 16'sh3333);
    add_sample(-16'sd2222, -16'sd3333);
    wait_idle();
    write_reg(REG_SKIP, 0);
    add_sample(16'sh0500, -16'sd1280);
    add_sample(16'sh0600, 16'sh0700);
    add_sample(-16'sd7, 16'sh0002);
    add_sample(16'sh0010, 16'sh0010);
    wait_idle();

    // zero chip count, then stop right after the last chip
    write_reg(REG_TOTAL, 0);
    add_sample(16'sh1000, 16'sh1000);
    add_sample(16'sh1000, 16'sh1000);
    wait_idle();
    write_reg(REG_PERIOD, 65536);
    write_reg(REG_TOTAL, chips_done + 2);
    add_sample(16'sh0100, -16'sd256);
    add_sample(-16'sd256, 16'sh0100);
    add_sample(16'sh0300, 16'sh0300);
    add_sample(16'sh0300, 16'sh0300);
    wait_idle();

    lean = 0;
    while (samples_queued < TARGET) begin
      wait_idle();
      gaps_on   <= (samples_queued < TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      stalls_on <= (samples_queued < TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       period = PER_W'($urandom_range(0, 65535));
        1:       period = $urandom_range(0, 1) ? 24'hFFFFFF : PER_W'($urandom_range(4194304, 16777215));
        default: period = PER_W'($urandom_range(65536, 655360));
      endcase
      write_reg(REG_PERIOD, DATA_W'(period));
      case ($urandom_range(0, 5))
        0:       write_reg(REG_HALF, 255);
        1:       write_reg(REG_HALF, $urandom_range(0, 255));
        default: write_reg(REG_HALF, DATA_W'(period >> 17));
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_SKIP, $urandom_range(0, 40));
      case ($urandom_range(0, 5))
        0:       write_reg(REG_TOTAL, chips_done + $urandom_range(1, 30));
        1:       write_reg(REG_TOTAL, 32'h1FFFF);
        default: write_reg(REG_TOTAL, chips_done + 2000);
      endcase
      count = $urandom_range(100, 200);
      for (int k = 0; k < count; k++) begin
        if (k % 8 == 0) lean = int'($urandom_range(0, 40000)) - 20000;
        add_sample(pick_sample(lean), pick_sample(-lean));
      end
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
